// ----- design/fssa_pkg.sv -----
// ----------------------------------------------------------------------------
// Frame sync symbol averager package
// Shared constants, payload structs and the frame mode type.
// ----------------------------------------------------------------------------
package fssa_pkg;

  // Frame geometry. SAMPLES_PER_SYMBOL must be a power of two, because the
  // symbol average is an arithmetic right shift.
  localparam int HEADER_SAMPLES     = 16;
  localparam int SAMPLES_PER_SYMBOL = 4;
  localparam int SPS_LOG2           = $clog2(SAMPLES_PER_SYMBOL);
  localparam int HEADER_SYMBOLS     = HEADER_SAMPLES / SAMPLES_PER_SYMBOL;
  localparam int HEADER_REM         = HEADER_SAMPLES % SAMPLES_PER_SYMBOL;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = SAMPLE_W + SPS_LOG2;
  localparam int COUNT_W  = 12;
  localparam int RUN_W    = $clog2(HEADER_SAMPLES);
  localparam int PHASE_W  = SPS_LOG2;
  localparam int SLOT_W   = (HEADER_SYMBOLS > 1) ? $clog2(HEADER_SYMBOLS) : 1;

  localparam logic [COUNT_W-1:0] SYMBOL_COUNT_RESET = COUNT_W'(30);

  typedef enum logic [1:0] {
    MODE_HUNTING    = 2'd0,
    MODE_COLLECTING = 2'd1,
    MODE_WAITING    = 2'd2
  } mode_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_re;
    logic signed [SAMPLE_W-1:0] sample_im;
    logic                       block_start;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] symbol_re;
    logic signed [SAMPLE_W-1:0] symbol_im;
    logic                       last;
  } symbol_t;

endpackage

// ----- design/fssa_core.sv -----
// ----------------------------------------------------------------------------
// Frame sync symbol averager core
// Input register, header hunt, symbol integration and header symbol burst.
// ----------------------------------------------------------------------------
module fssa_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [fssa_pkg::COUNT_W-1:0] symbol_count,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  fssa_pkg::sample_t        in_item,
  output logic                     push,
  output fssa_pkg::symbol_t        push_item,
  input  logic                     push_ok
);
  import fssa_pkg::*;

  typedef logic signed [SUM_W-1:0] sum_t;

  function automatic symbol_t make_symbol(sum_t re, sum_t im, logic fin);
    sum_t    sh_re;
    sum_t    sh_im;
    symbol_t s;
    sh_re       = re >>> SPS_LOG2;
    sh_im       = im >>> SPS_LOG2;
    s.symbol_re = sh_re[SAMPLE_W-1:0];
    s.symbol_im = sh_im[SAMPLE_W-1:0];
    s.last      = fin;
    return s;
  endfunction

  // Input register
  logic        item_valid;
  sample_t     item;

  // Frame state
  mode_t              mode, mode_next;
  logic [RUN_W-1:0]   run_len, run_len_next;
  sum_t               grp_re, grp_re_next;
  sum_t               grp_im, grp_im_next;
  logic [PHASE_W-1:0] phase, phase_next;
  logic [COUNT_W-1:0] sent, sent_next;
  logic               burst_on, burst_on_next;
  logic [SLOT_W-1:0]  burst_idx, burst_idx_next;

  // Header symbol sums, written once per header group before being read.
  sum_t               hdr_re [HEADER_SYMBOLS];
  sum_t               hdr_im [HEADER_SYMBOLS];
  logic               hdr_we;
  logic [SLOT_W-1:0]  hdr_slot;

  logic               fire;
  mode_t              mode_v;
  logic [RUN_W-1:0]   run_v;
  logic [RUN_W-1:0]   slot_full;
  logic [PHASE_W-1:0] phase_v;
  sum_t               grp_re_v, grp_im_v;
  sum_t               acc_re, acc_im;
  sum_t               x_re, x_im;
  logic [COUNT_W-1:0] sent_v, sent_inc, flen;
  logic               fin;
  logic               positive;

  always_comb begin
    fire     = item_valid && !burst_on && push_ok;
    in_ready = !item_valid || fire;

    mode_next      = mode;
    run_len_next   = run_len;
    grp_re_next    = grp_re;
    grp_im_next    = grp_im;
    phase_next     = phase;
    sent_next      = sent;
    burst_on_next  = burst_on;
    burst_idx_next = burst_idx;
    hdr_we         = 1'b0;
    push           = 1'b0;
    push_item      = '0;
    acc_re         = '0;
    acc_im         = '0;

    x_re     = {{SPS_LOG2{item.sample_re[SAMPLE_W-1]}}, item.sample_re};
    x_im     = {{SPS_LOG2{item.sample_im[SAMPLE_W-1]}}, item.sample_im};
    positive = !item.sample_re[SAMPLE_W-1] && (item.sample_re != '0) &&
               !item.sample_im[SAMPLE_W-1] && (item.sample_im != '0);
    flen     = (symbol_count == '0) ? COUNT_W'(1) : symbol_count;

    // A block start clears the frame before the same sample is tested.
    mode_v   = item.block_start ? MODE_HUNTING : mode;
    run_v    = item.block_start ? '0 : run_len;
    phase_v  = item.block_start ? '0 : phase;
    grp_re_v = item.block_start ? '0 : grp_re;
    grp_im_v = item.block_start ? '0 : grp_im;
    sent_v   = item.block_start ? '0 : sent;

    slot_full = run_v >> SPS_LOG2;
    hdr_slot  = slot_full[SLOT_W-1:0];
    sent_inc  = fire ? sent_v + COUNT_W'(1) : sent + COUNT_W'(1);
    fin       = sent_inc >= flen;

    if (fire) begin
      mode_next    = mode_v;
      run_len_next = run_v;
      phase_next   = phase_v;
      grp_re_next  = grp_re_v;
      grp_im_next  = grp_im_v;
      sent_next    = sent_v;
      unique case (mode_v)
        MODE_HUNTING: begin
          if (positive) begin
            // The group accumulator collects each header group; a finished
            // group is stored in its header slot.
            acc_re      = (run_v[PHASE_W-1:0] == '0) ? x_re : grp_re_v + x_re;
            acc_im      = (run_v[PHASE_W-1:0] == '0) ? x_im : grp_im_v + x_im;
            grp_re_next = acc_re;
            grp_im_next = acc_im;
            if ((run_v[PHASE_W-1:0] == PHASE_W'(SAMPLES_PER_SYMBOL - 1)) &&
                (slot_full < RUN_W'(HEADER_SYMBOLS))) begin
              hdr_we = 1'b1;
            end
            if (run_v == RUN_W'(HEADER_SAMPLES - 1)) begin
              run_len_next   = '0;
              sent_next      = '0;
              phase_next     = PHASE_W'(HEADER_REM);
              mode_next      = MODE_COLLECTING;
              burst_on_next  = 1'b1;
              burst_idx_next = '0;
            end else begin
              run_len_next = run_v + RUN_W'(1);
            end
          end else begin
            run_len_next = '0;
          end
        end
        MODE_COLLECTING: begin
          acc_re      = (phase_v == '0) ? x_re : grp_re_v + x_re;
          acc_im      = (phase_v == '0) ? x_im : grp_im_v + x_im;
          grp_re_next = acc_re;
          grp_im_next = acc_im;
          phase_next  = phase_v + PHASE_W'(1);
          if (phase_v == PHASE_W'(SAMPLES_PER_SYMBOL - 1)) begin
            push      = 1'b1;
            push_item = make_symbol(acc_re, acc_im, fin);
            sent_next = sent_inc;
            if (fin) begin
              mode_next = MODE_WAITING;
            end
          end
        end
        MODE_WAITING: begin
        end
        default: begin
          mode_next = MODE_HUNTING;
        end
      endcase
    end else if (burst_on && push_ok) begin
      push      = 1'b1;
      push_item = make_symbol(hdr_re[burst_idx], hdr_im[burst_idx], fin);
      sent_next = sent_inc;
      if (fin) begin
        burst_on_next = 1'b0;
        mode_next     = MODE_WAITING;
      end else if (burst_idx == SLOT_W'(HEADER_SYMBOLS - 1)) begin
        burst_on_next = 1'b0;
      end else begin
        burst_idx_next = burst_idx + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      mode       <= MODE_HUNTING;
      run_len    <= '0;
      grp_re     <= '0;
      grp_im     <= '0;
      phase      <= '0;
      sent       <= '0;
      burst_on   <= 1'b0;
      burst_idx  <= '0;
    end else begin
      if (in_ready) begin
        item_valid <= in_valid;
      end
      mode      <= mode_next;
      run_len   <= run_len_next;
      grp_re    <= grp_re_next;
      grp_im    <= grp_im_next;
      phase     <= phase_next;
      sent      <= sent_next;
      burst_on  <= burst_on_next;
      burst_idx <= burst_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
    if (hdr_we) begin
      hdr_re[hdr_slot] <= grp_re_next;
      hdr_im[hdr_slot] <= grp_im_next;
    end
  end

endmodule

// ----- design/fssa_out_buf.sv -----
// ----------------------------------------------------------------------------
// Frame sync symbol averager output buffer
// Two-entry register queue that decouples the core from output stalls.
// ----------------------------------------------------------------------------
module fssa_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  fssa_pkg::symbol_t push_item,
  output logic              push_ok,
  output logic              out_valid,
  input  logic              out_ready,
  output fssa_pkg::symbol_t out_item
);
  import fssa_pkg::*;

  symbol_t     entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        pop;

  always_comb begin
    out_valid = (count != 2'd0);
    pop       = out_valid && out_ready;
    push_ok   = (count != 2'd2) || pop;
    out_item  = entry[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- design/frame_sync_symbol_averager.sv -----
// ----------------------------------------------------------------------------
// Frame sync symbol averager
// Hunts for a positive-quadrant header in a complex sample stream, then
// averages each group of samples into one symbol for a configured frame.
// ----------------------------------------------------------------------------
//
//   channel   direction  payload            request accepted when
//   sample    in         fssa_pkg::sample_t sample_valid && sample_ready
//   symbol    out        fssa_pkg::symbol_t symbol_valid && symbol_ready
//   cfg       in         symbol_count       cfg_valid && cfg_ready
//
// One sample request is taken every cycle unless the header burst or a full
// result buffer stalls it; each symbol comes through the input register,
// then the result buffer. When a header completes, the stored header
// symbols are sent one per cycle from the header sum registers while the
// buffer has room, and sample input pauses. Output stalls are absorbed by
// a two-entry result buffer before they reach the sample side. rst is
// synchronous and clears all control state; symbol_count returns to 30.
//
module frame_sync_symbol_averager (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         sample_valid,
  output logic                         sample_ready,
  input  fssa_pkg::sample_t            sample,
  output logic                         symbol_valid,
  input  logic                         symbol_ready,
  output fssa_pkg::symbol_t            symbol,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [fssa_pkg::COUNT_W-1:0] cfg_data
);
  import fssa_pkg::*;

  // Number of symbols per detected frame. Zero behaves as one.
  logic [COUNT_W-1:0] symbol_count;

  logic    push;
  logic    push_ok;
  symbol_t push_item;

  // The register port never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count <= SYMBOL_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      symbol_count <= cfg_data;
    end
  end

  // Header hunt, symbol integration and the header burst sequencer.
  fssa_core u_core (
    .clk          (clk),
    .rst          (rst),
    .symbol_count (symbol_count),
    .in_valid     (sample_valid),
    .in_ready     (sample_ready),
    .in_item      (sample),
    .push         (push),
    .push_item    (push_item),
    .push_ok      (push_ok)
  );

  // Result buffer between the core and the symbol channel.
  fssa_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .push_ok   (push_ok),
    .out_valid (symbol_valid),
    .out_ready (symbol_ready),
    .out_item  (symbol)
  );

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// Frame sync symbol averager testbench
// Sends sample requests through the valid/ready sample port, mirrors the
// header hunt and the symbol averaging in a local predictor, and checks every
// symbol request that leaves the block, field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import fssa_pkg::*;

  localparam int IDLE_PCT        = 28;
  localparam int HOLD_CYCLES     = 150;
  localparam int DRAIN_LIMIT     = 4000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int RANDOM_SAMPLES  = 30;
  localparam int MAX_REPORTS     = 30;

  // --------------------------------------------------------------------------
  // Clock, reset and the block's ports. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                sample_valid = 1'b0;
  logic                sample_ready;
  sample_t             sample       = '0;
  logic                symbol_valid;
  logic                symbol_ready = 1'b0;
  symbol_t             symbol;
  logic                cfg_valid    = 1'b0;
  logic                cfg_ready;
  logic [COUNT_W-1:0]  cfg_data     = '0;

  always #10 clk = ~clk;

  frame_sync_symbol_averager i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .symbol_valid (symbol_valid),
    .symbol_ready (symbol_ready),
    .symbol       (symbol),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Predictor state. This is a private copy of the frame state and of the
  // symbol_count register; it is advanced once per accepted sample request.
  // --------------------------------------------------------------------------
  mode_t                     frame_mode;
  int                        run_count;
  logic signed [SUM_W-1:0]   header_re [HEADER_SYMBOLS];
  logic signed [SUM_W-1:0]   header_im [HEADER_SYMBOLS];
  logic signed [SUM_W-1:0]   group_re;
  logic signed [SUM_W-1:0]   group_im;
  int                        group_phase;
  logic [COUNT_W-1:0]        symbols_out;
  logic [COUNT_W-1:0]        count_cfg;

  // Symbols the block owes us, oldest first.
  symbol_t pending_symbols [$];

  // Run statistics and the error count.
  int mismatches      = 0;
  int samples_used    = 0;
  int headers_found   = 0;
  int symbols_checked = 0;
  int frame_ends      = 0;
  int cfg_writes      = 0;

  // Idle rates. gap_pct is owned by the stimulus process; stall_pct is only
  // changed with nonblocking writes because the output process reads it.
  int gap_pct   = IDLE_PCT;
  int stall_pct = IDLE_PCT;

  // A long output hold is requested by bumping hold_request; the output
  // process notices the change on the next edge and counts the hold itself.
  int hold_request = 0;
  int hold_seen;
  int hold_left;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t ns] mismatch: %s", $realtime, what);
    end
  endtask

  // Averages one group sum (floor division by the group size), advances the
  // frame's symbol count and queues the symbol. Returns the last flag.
  function automatic logic emit_symbol(input logic signed [SUM_W-1:0] sum_re,
                                       input logic signed [SUM_W-1:0] sum_im);
    symbol_t                 sym;
    logic signed [SUM_W-1:0] avg_re;
    logic signed [SUM_W-1:0] avg_im;
    logic [COUNT_W-1:0]      frame_len;
    // A zero count behaves like a count of one.
    frame_len     = (count_cfg == '0) ? COUNT_W'(1) : count_cfg;
    symbols_out   = symbols_out + COUNT_W'(1);
    avg_re        = sum_re >>> SPS_LOG2;
    avg_im        = sum_im >>> SPS_LOG2;
    sym.symbol_re = avg_re[SAMPLE_W-1:0];
    sym.symbol_im = avg_im[SAMPLE_W-1:0];
    // If the count was lowered below what was already sent, this is last too.
    sym.last      = (symbols_out >= frame_len);
    pending_symbols.push_back(sym);
    return sym.last;
  endfunction

  function automatic void predict_symbols(input sample_t s);
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
    int                         slot;
    logic                       done;
    re = s.sample_re;
    im = s.sample_im;
    // A block start abandons any frame and retests this same sample.
    if (s.block_start) begin
      frame_mode  = MODE_HUNTING;
      run_count   = 0;
      group_phase = 0;
      group_re    = '0;
      group_im    = '0;
      symbols_out = '0;
    end
    if (frame_mode != MODE_WAITING) samples_used++;
    case (frame_mode)
      MODE_HUNTING: begin
        if (re > 0 && im > 0) begin
          slot = run_count / SAMPLES_PER_SYMBOL;
          if (run_count % SAMPLES_PER_SYMBOL == 0) begin
            header_re[slot] = re;
            header_im[slot] = im;
          end else begin
            header_re[slot] = header_re[slot] + re;
            header_im[slot] = header_im[slot] + im;
          end
          run_count++;
          if (run_count >= HEADER_SAMPLES) begin
            // Header complete: all header symbols go out now, unless the
            // frame is shorter than the header.
            headers_found++;
            symbols_out = '0;
            group_phase = HEADER_REM;
            frame_mode  = MODE_COLLECTING;
            done        = 1'b0;
            for (int i = 0; i < HEADER_SYMBOLS && !done; i++) begin
              done = emit_symbol(header_re[i], header_im[i]);
            end
            if (done) frame_mode = MODE_WAITING;
            run_count = 0;
          end
        end else begin
          // Zero or negative in either part breaks the run.
          run_count = 0;
        end
      end
      MODE_COLLECTING: begin
        if (group_phase == 0) begin
          group_re = re;
          group_im = im;
        end else begin
          group_re = group_re + re;
          group_im = group_im + im;
        end
        group_phase++;
        if (group_phase >= SAMPLES_PER_SYMBOL) begin
          group_phase = 0;
          if (emit_symbol(group_re, group_im)) frame_mode = MODE_WAITING;
        end
      end
      default: begin
        // Waiting for a block start: the sample is dropped.
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Output side: random stalls, the long hold, and the symbol checker.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      symbol_ready <= 1'b0;
      hold_seen    <= 0;
      hold_left    <= 0;
    end else if (hold_request != hold_seen) begin
      hold_seen    <= hold_request;
      hold_left    <= HOLD_CYCLES;
      symbol_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      symbol_ready <= 1'b0;
    end else begin
      symbol_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  symbol_t wanted;

  always @(posedge clk) begin
    if (!rst && symbol_valid && symbol_ready) begin
      if (pending_symbols.size() == 0) begin
        report_mismatch($sformatf("unexpected symbol re=%0d im=%0d last=%0b",
                                  symbol.symbol_re, symbol.symbol_im, symbol.last));
      end else begin
        wanted = pending_symbols.pop_front();
        symbols_checked++;
        if (wanted.last) frame_ends++;
        if (symbol.symbol_re !== wanted.symbol_re) begin
          report_mismatch($sformatf("symbol %0d: symbol_re got %0d, want %0d",
                                    symbols_checked, symbol.symbol_re, wanted.symbol_re));
        end
        if (symbol.symbol_im !== wanted.symbol_im) begin
          report_mismatch($sformatf("symbol %0d: symbol_im got %0d, want %0d",
                                    symbols_checked, symbol.symbol_im, wanted.symbol_im));
        end
        if (symbol.last !== wanted.last) begin
          report_mismatch($sformatf("symbol %0d: last got %0b, want %0b",
                                    symbols_checked, symbol.last, wanted.last));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers. All of them are entered just after a rising edge.
  // --------------------------------------------------------------------------

  // Offers one sample request, with a random gap first, and waits for it to be
  // taken. Valid is left high so back-to-back requests follow without a gap.
  // Each idle cycle is drawn on its own, so the idle share matches gap_pct.
  task automatic send_sample(input logic [SAMPLE_W-1:0] re,
                             input logic [SAMPLE_W-1:0] im,
                             input logic bs);
    sample_t item;
    item.sample_re   = re;
    item.sample_im   = im;
    item.block_start = bs;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      sample_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    sample_valid <= 1'b1;
    sample       <= item;
    do @(posedge clk); while (!sample_ready);
    predict_symbols(item);
  endtask

  // Stops offering samples and waits until every owed symbol has arrived.
  // Always lets at least one edge pass, so valid is never dropped and raised
  // in the same step.
  task automatic wait_drain(input bit settle);
    int guard;
    guard = 0;
    sample_valid <= 1'b0;
    do begin
      @(posedge clk);
      guard++;
    end while (pending_symbols.size() != 0 && guard < DRAIN_LIMIT);
    if (pending_symbols.size() != 0) begin
      report_mismatch($sformatf("%0d symbols never arrived", pending_symbols.size()));
      pending_symbols.delete();
    end
    // Samples that cause no symbol may still be inside the block.
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes only happen once the block has gone quiet.
  task automatic set_symbol_count(input logic [COUNT_W-1:0] value);
    wait_drain(1'b1);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    count_cfg = value;
    cfg_writes++;
  endtask

  function automatic logic [SAMPLE_W-1:0] any_value();
    case ($urandom_range(7))
      0:       return SAMPLE_W'(16'h8000);
      1:       return SAMPLE_W'(16'h7fff);
      2:       return '0;
      3:       return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] positive_value();
    case ($urandom_range(7))
      0:       return SAMPLE_W'(1);
      1:       return SAMPLE_W'(16'h7fff);
      default: return SAMPLE_W'($urandom_range(1, 32767));
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] nonpositive_value();
    if ($urandom_range(2) == 0) return '0;
    return SAMPLE_W'(16'h8000) | SAMPLE_W'($urandom);
  endfunction

  // Number of groups after the header that completes a frame at the
  // current count.
  function automatic int full_groups();
    int len;
    len = (count_cfg == '0) ? 1 : int'(count_cfg);
    return (len > HEADER_SYMBOLS) ? len - HEADER_SYMBOLS : 0;
  endfunction

  task automatic send_groups(input int groups);
    for (int i = 0; i < groups * SAMPLES_PER_SYMBOL; i++) begin
      send_sample(any_value(), any_value(), 1'b0);
    end
  endtask

  // A block start, a positive header, then the given number of symbol
  // groups. A broken header has one sample that fails the positive test.
  task automatic send_frame(input int groups, input bit broken);
    int break_at;
    break_at = broken ? $urandom_range(0, HEADER_SAMPLES - 1) : -1;
    for (int i = 0; i < HEADER_SAMPLES; i++) begin
      if (i == break_at) begin
        case ($urandom_range(2))
          0:       send_sample(nonpositive_value(), positive_value(), i == 0);
          1:       send_sample(positive_value(), nonpositive_value(), i == 0);
          default: send_sample(nonpositive_value(), nonpositive_value(), i == 0);
        endcase
      end else begin
        send_sample(positive_value(), positive_value(), i == 0);
      end
    end
    send_groups(groups);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // One frame by hand: a sample with a zero imaginary part that starts no
  // run, a header with full-scale and minimum positive groups, a full
  // negative group, a group whose sum is -1 (floor gives -1, not 0), and a
  // sample dropped while waiting for the next block start.
  task automatic test_directed_frame();
    set_symbol_count(COUNT_W'(6));
    send_sample(SAMPLE_W'(100), '0, 1'b0);
    for (int i = 0; i < HEADER_SAMPLES; i++) begin
      case (i / SAMPLES_PER_SYMBOL)
        0:       send_sample(SAMPLE_W'(16'h7fff), SAMPLE_W'(16'h7fff), i == 0);
        1:       send_sample(SAMPLE_W'(1), SAMPLE_W'(1), 1'b0);
        default: send_sample(positive_value(), positive_value(), 1'b0);
      endcase
    end
    for (int i = 0; i < SAMPLES_PER_SYMBOL; i++) begin
      send_sample(SAMPLE_W'(16'h8000), SAMPLE_W'(16'h8000), 1'b0);
    end
    for (int i = 0; i < SAMPLES_PER_SYMBOL; i++) begin
      send_sample((i == 0) ? '1 : '0, (i == 0) ? SAMPLE_W'(3) : '0, 1'b0);
    end
    send_sample(SAMPLE_W'(16'h1234), SAMPLE_W'(16'h4321), 1'b0);
  endtask

  // Frames no longer than the header, a zero count among them, each followed
  // by a group that is dropped while waiting.
  task automatic test_short_frames();
    for (int c = 0; c <= HEADER_SYMBOLS; c++) begin
      set_symbol_count(COUNT_W'(c));
      send_frame(1, 1'b0);
    end
  endtask

  // Frames cut short by a block start, in the middle of the symbol groups and
  // in the middle of the header, plus a broken header and a block start that
  // lands on a waiting block.
  task automatic test_abandoned_frames();
    set_symbol_count(COUNT_W'(9));
    send_frame(2, 1'b0);
    for (int i = 0; i < 7; i++) send_sample(positive_value(), positive_value(), i == 0);
    send_frame(full_groups(), 1'b1);
    send_frame(full_groups(), 1'b0);
    send_sample(any_value(), any_value(), 1'b1);
  endtask

  // The count is lowered while a frame is open: once below what was already
  // sent, once to exactly one more symbol.
  task automatic test_count_lowered();
    set_symbol_count(COUNT_W'(30));
    send_frame(3, 1'b0);
    set_symbol_count(COUNT_W'(5));
    send_groups(2);
    set_symbol_count(COUNT_W'(4095));
    send_frame(2, 1'b0);
    set_symbol_count(COUNT_W'(7));
    send_groups(2);
  endtask

  // The output is held for a long stretch while samples keep coming, so the
  // block must stall its input. Then the sender stops mid-frame until every
  // owed symbol is out, and carries on.
  task automatic test_backpressure();
    set_symbol_count(COUNT_W'(14));
    gap_pct = 0;
    hold_request <= hold_request + 1;
    send_frame(10, 1'b0);
    send_frame(2, 1'b0);
    wait_drain(1'b0);
    send_groups(8);
    gap_pct = IDLE_PCT;
  endtask

  // Mostly well-formed frames with random content at changing counts, some
  // cut short, some with broken headers, and some plain noise. The first
  // two thirds run with no idling on either side.
  task automatic test_random_traffic();
    int                 target;
    int                 next_cfg;
    int                 kind;
    int                 groups;
    logic [COUNT_W-1:0] count;
    target   = samples_used + RANDOM_SAMPLES;
    next_cfg = samples_used;
    gap_pct  = 0;
    stall_pct <= 0;
    while (samples_used < target) begin
      if (samples_used >= next_cfg) begin
        case ($urandom_range(9))
          0:       count = '0;
          1:       count = '1;
          2:       count = COUNT_W'($urandom_range(11, 40));
          default: count = COUNT_W'($urandom_range(1, 10));
        endcase
        set_symbol_count(count);
        next_cfg = samples_used + 70;
      end
      if (samples_used > target - RANDOM_SAMPLES / 3 && gap_pct == 0) begin
        gap_pct = IDLE_PCT;
        stall_pct <= IDLE_PCT;
      end
      groups = full_groups();
      if (groups > 12) groups = 12;
      kind = $urandom_range(99);
      if (kind < 70) begin
        send_frame(groups + $urandom_range(0, 1), 1'b0);
      end else if (kind < 82) begin
        send_frame($urandom_range(0, groups), 1'b0);
      end else if (kind < 92) begin
        send_frame(groups, 1'b1);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_sample(any_value(), any_value(), $urandom_range(7) == 0);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    frame_mode  = MODE_HUNTING;
    run_count   = 0;
    group_re    = '0;
    group_im    = '0;
    group_phase = 0;
    symbols_out = '0;
    count_cfg   = SYMBOL_COUNT_RESET;
    for (int i = 0; i < HEADER_SYMBOLS; i++) begin
      header_re[i] = '0;
      header_im[i] = '0;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed_frame();
    test_short_frames();
    test_abandoned_frames();
    test_count_lowered();
    test_backpressure();
    test_random_traffic();

    // Everything sent: wait for the last symbols, then let the block settle to
    // catch anything it should not have produced.
    wait_drain(1'b1);

    $display("Run covered %0d samples, %0d headers, %0d symbols checked, %0d frame ends.",
             samples_used, headers_found, symbols_checked, frame_ends);
    $display("Symbol count written %0d times, from 0 up to 4095, with one long output hold.",
             cfg_writes);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("Run stopped by watchdog with %0d symbols still owed.", pending_symbols.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
